// ----- rtl/core/periodic_deadline_timer_table_defines.svh -----
// assertion macros for the periodic deadline timer table
`ifndef PERIODIC_DEADLINE_TIMER_TABLE_DEFINES_SVH
`define PERIODIC_DEADLINE_TIMER_TABLE_DEFINES_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define PDTT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdtt assertion failed");
// antecedent implies consequent in the next cycle
`define PDTT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdtt assertion failed");
`else
`define PDTT_ASSERT_IMP(label, ante, cons)
`define PDTT_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ----- rtl/core/pdtt_pkg.sv -----
// types and constants of the periodic deadline timer table
`default_nettype none

package pdtt_pkg;

  // time, period, seconds, handler id and kind widths
  localparam int TIME_W   = 48;
  localparam int PER_W    = 42;
  localparam int SEC_W    = 32;
  localparam int HID_W    = 8;
  localparam int KIND_W   = 3;

  // seconds to milliseconds
  localparam int MS_W = 10;
  localparam logic [MS_W-1:0] MS_PER_SEC = 10'd1000;

  // most fired results per tick
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // result kinds
  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_REG   = 3'd0;
  localparam kind_t KIND_PAST  = 3'd1;
  localparam kind_t KIND_FULL  = 3'd2;
  localparam kind_t KIND_FIRED = 3'd3;
  localparam kind_t KIND_NONE  = 3'd4;

  // sequencer states
  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_MUL_DL   = 12'b0000_0000_0010,
    S_MUL_PER  = 12'b0000_0000_0100,
    S_REG_CHK  = 12'b0000_0000_1000,
    S_REG_SCAN = 12'b0000_0001_0000,
    S_DUE_RD   = 12'b0000_0010_0000,
    S_DUE_CMP  = 12'b0000_0100_0000,
    S_SEL_RD   = 12'b0000_1000_0000,
    S_SEL_CMP  = 12'b0001_0000_0000,
    S_FIRE_RD  = 12'b0010_0000_0000,
    S_FIRE     = 12'b0100_0000_0000,
    S_NONE     = 12'b1000_0000_0000
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/periodic_deadline_timer_table.sv -----
// Periodic deadline timer table: timer slots scanned by one shared comparator.
//
// Input channel in_*: one beat is one command. in_tuser is the command
// (0 register a timer, 1 tick). A register beat converts its deadline and
// period from seconds to milliseconds, rejects a deadline earlier than now
// and otherwise stores the timer in the lowest free slot, or reports a full
// table. A tick beat fires every armed slot whose deadline is earlier than
// now, earliest deadline first, lower slot on ties, at most 16 per tick.
// Output channel out_*: one beat per result, out_tlast on the final one.
// A register beat passes the shared multiplier twice, for the deadline and
// then the period, is checked against now, then takes a free-slot scan.
// A tick runs the due scan over every slot, then per fired timer a scan for
// the earliest due slot, a read of that slot and the report; a tick that fires
// nothing answers after the due and select scans. With the single comparator
// and single registered read port, each slot gets a read and a compare state.
// One command is worked on at a time; in_tready is high only between them.
// A result waits in the output register while the receiver stalls, and the
// sequencer holds until that register is free.
// Reset clears all slots and the output register; slot contents need none.
`default_nettype none
`include "periodic_deadline_timer_table_defines.svh"

module periodic_deadline_timer_table #(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // command beats
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // now_ms[47:0], deadline_sec[79:48], period_sec[111:80], handler_id[119:112]
  input  wire logic [119:0] in_tdata,
  // cmd[0]
  input  wire logic [0:0]   in_tuser,
  // result beats
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // handler_id[7:0]
  output logic [7:0]        out_tdata,
  // kind[2:0]
  output logic [2:0]        out_tuser,
  output logic              out_tlast
);

  import pdtt_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  // control state
  state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [IDX_W-1:0]       best_r, best_nxt;
  logic                   found_r, found_nxt;
  logic [NUM_SLOTS-1:0]   valid_r, valid_nxt;
  logic [NUM_SLOTS-1:0]   due_r, due_nxt;
  logic [CNT_W-1:0]       fire_cnt_r, fire_cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // payload registers
  logic [TIME_W-1:0]      now_r, now_nxt;
  logic [SEC_W-1:0]       dsec_r, dsec_nxt;
  logic [SEC_W-1:0]       psec_r, psec_nxt;
  logic [HID_W-1:0]       hid_r, hid_nxt;
  logic [PER_W-1:0]       dl_r, dl_nxt;
  logic [PER_W-1:0]       per_r, per_nxt;
  logic [TIME_W-1:0]      best_dl_r, best_dl_nxt;
  kind_t                  out_kind_r, out_kind_nxt;
  logic [HID_W-1:0]       out_id_r, out_id_nxt;
  logic                   out_last_r, out_last_nxt;

  // slot memories
  logic [TIME_W-1:0]      dl_mem  [NUM_SLOTS];
  logic [PER_W-1:0]       per_mem [NUM_SLOTS];
  logic [HID_W-1:0]       hid_mem [NUM_SLOTS];
  logic [TIME_W-1:0]      rd_dl_r;
  logic [PER_W-1:0]       rd_per_r;
  logic [HID_W-1:0]       rd_hid_r;
  logic [IDX_W-1:0]       rd_addr;
  logic [IDX_W-1:0]       wr_addr;
  logic                   dl_we, per_we, hid_we;
  logic [TIME_W-1:0]      dl_wdata;

  // shared units
  logic [TIME_W-1:0]      cmp_a, cmp_b;
  logic                   cmp_gt;
  logic [SEC_W-1:0]       mul_src;
  logic [PER_W-1:0]       mul_prod;
  logic [TIME_W:0]        rearm_sum;
  logic [TIME_W-1:0]      rearm_dl;
  logic [NUM_SLOTS-1:0]   due_left;
  logic                   emit_ok;
  logic                   fire_last;
  logic                   reg_store;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_id_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // output register free for a new result
  assign emit_ok = !out_valid_r || out_tready;

  // shared multiplier, seconds to milliseconds
  assign mul_src  = (state_r == S_MUL_PER) ? psec_r : dsec_r;
  assign mul_prod = {{(PER_W-SEC_W){1'b0}}, mul_src} *
                    {{(PER_W-MS_W){1'b0}}, MS_PER_SEC};

  // shared comparator
  always_comb begin
    case (state_r)
      S_REG_CHK: begin
        cmp_a = now_r;
        cmp_b = {{(TIME_W-PER_W){1'b0}}, dl_r};
      end
      S_SEL_CMP: begin
        cmp_a = best_dl_r;
        cmp_b = rd_dl_r;
      end
      default: begin
        cmp_a = now_r;
        cmp_b = rd_dl_r;
      end
    endcase
  end
  assign cmp_gt = cmp_a > cmp_b;

  // rearm deadline, saturating
  assign rearm_sum = {1'b0, now_r} + {{(TIME_W-PER_W+1){1'b0}}, rd_per_r};
  assign rearm_dl  = rearm_sum[TIME_W] ? {TIME_W{1'b1}} : rearm_sum[TIME_W-1:0];

  // due slots left after the current fire
  assign due_left  = due_r & ~(NUM_SLOTS'(1) << best_r);
  assign fire_last = !(|due_left) || (fire_cnt_r == CNT_W'(MAX_RESULTS - 1));

  // memory addressing
  assign rd_addr  = ((state_r == S_FIRE_RD) || (state_r == S_FIRE)) ? best_r : idx_r;
  assign wr_addr  = (state_r == S_FIRE) ? best_r : idx_r;
  assign reg_store = (state_r == S_REG_SCAN) && !valid_r[idx_r] && emit_ok;

  // sequencer
  always_comb begin
    logic take;
    take          = 1'b0;
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    best_nxt      = best_r;
    found_nxt     = found_r;
    valid_nxt     = valid_r;
    due_nxt       = due_r;
    fire_cnt_nxt  = fire_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    now_nxt       = now_r;
    dsec_nxt      = dsec_r;
    psec_nxt      = psec_r;
    hid_nxt       = hid_r;
    dl_nxt        = dl_r;
    per_nxt       = per_r;
    best_dl_nxt   = best_dl_r;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_last_nxt  = out_last_r;
    dl_we         = 1'b0;
    per_we        = 1'b0;
    hid_we        = 1'b0;
    dl_wdata      = {{(TIME_W-PER_W){1'b0}}, dl_r};

    case (state_r)
      // take a command beat
      S_IDLE: begin
        if (in_tvalid) begin
          now_nxt      = in_tdata[47:0];
          dsec_nxt     = in_tdata[79:48];
          psec_nxt     = in_tdata[111:80];
          hid_nxt      = in_tdata[119:112];
          idx_nxt      = '0;
          found_nxt    = 1'b0;
          fire_cnt_nxt = '0;
          state_nxt    = in_tuser[0] ? S_DUE_RD : S_MUL_DL;
        end
      end
      // deadline in milliseconds
      S_MUL_DL: begin
        dl_nxt    = mul_prod;
        state_nxt = S_MUL_PER;
      end
      // period in milliseconds
      S_MUL_PER: begin
        per_nxt   = mul_prod;
        state_nxt = S_REG_CHK;
      end
      // reject a deadline already passed
      S_REG_CHK: begin
        if (cmp_gt) begin
          if (emit_ok) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_PAST;
            out_id_nxt    = hid_r;
            out_last_nxt  = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          state_nxt = S_REG_SCAN;
        end
      end
      // look for the lowest free slot
      S_REG_SCAN: begin
        if (!valid_r[idx_r]) begin
          if (emit_ok) begin
            dl_we          = 1'b1;
            per_we         = 1'b1;
            hid_we         = 1'b1;
            valid_nxt[idx_r] = 1'b1;
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = KIND_REG;
            out_id_nxt     = hid_r;
            out_last_nxt   = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else if (idx_r == LAST_IDX) begin
          if (emit_ok) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_FULL;
            out_id_nxt    = hid_r;
            out_last_nxt  = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      // due scan, read one slot
      S_DUE_RD: begin
        state_nxt = S_DUE_CMP;
      end
      // due scan, compare with now
      S_DUE_CMP: begin
        due_nxt[idx_r] = valid_r[idx_r] && cmp_gt;
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = S_SEL_RD;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_DUE_RD;
        end
      end
      // earliest due slot, read one slot
      S_SEL_RD: begin
        state_nxt = S_SEL_CMP;
      end
      // earliest due slot, strict compare keeps the lower slot on ties
      S_SEL_CMP: begin
        take = due_r[idx_r] && (!found_r || cmp_gt);
        if (take) begin
          best_nxt    = idx_r;
          best_dl_nxt = rd_dl_r;
          found_nxt   = 1'b1;
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = (found_r || take) ? S_FIRE_RD : S_NONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SEL_RD;
        end
      end
      // read period and handler of the chosen slot
      S_FIRE_RD: begin
        state_nxt = S_FIRE;
      end
      // report the fire, then rearm or free
      S_FIRE: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_FIRED;
          out_id_nxt    = rd_hid_r;
          out_last_nxt  = fire_last;
          due_nxt       = due_left;
          fire_cnt_nxt  = fire_cnt_r + 1'b1;
          if (rd_per_r != '0) begin
            dl_we    = 1'b1;
            dl_wdata = rearm_dl;
          end else begin
            valid_nxt[best_r] = 1'b0;
          end
          if (fire_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = '0;
            found_nxt = 1'b0;
            state_nxt = S_SEL_RD;
          end
        end
      end
      // nothing was due
      S_NONE: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_NONE;
          out_id_nxt    = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      best_r      <= '0;
      found_r     <= 1'b0;
      valid_r     <= '0;
      due_r       <= '0;
      fire_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      best_r      <= best_nxt;
      found_r     <= found_nxt;
      valid_r     <= valid_nxt;
      due_r       <= due_nxt;
      fire_cnt_r  <= fire_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    now_r      <= now_nxt;
    dsec_r     <= dsec_nxt;
    psec_r     <= psec_nxt;
    hid_r      <= hid_nxt;
    dl_r       <= dl_nxt;
    per_r      <= per_nxt;
    best_dl_r  <= best_dl_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_last_r <= out_last_nxt;
  end

  // slot memories, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (dl_we) begin
      dl_mem[wr_addr] <= dl_wdata;
    end
    if (per_we) begin
      per_mem[wr_addr] <= per_r;
    end
    if (hid_we) begin
      hid_mem[wr_addr] <= hid_r;
    end
    rd_dl_r  <= dl_mem[rd_addr];
    rd_per_r <= per_mem[rd_addr];
    rd_hid_r <= hid_mem[rd_addr];
  end

  // checks
  `PDTT_ASSERT_NXT(a_busy_after_cmd, in_tvalid && in_tready, !in_tready)
  `PDTT_ASSERT_NXT(a_store_adds_slot, reg_store, $countones(valid_r) == $past($countones(valid_r)) + 1)
  `PDTT_ASSERT_IMP(a_none_only_unfired, state_r == S_NONE, fire_cnt_r == '0)

endmodule

`default_nettype wire
